### src/isu_pkg.sv
// shared constants and codes for the ising metropolis update unit
package isu_pkg;

  // lattice size defaults
  localparam int DEFAULT_WIDTH  = 64;
  localparam int DEFAULT_HEIGHT = 64;

  // field widths
  localparam int COORD_W = 8;
  localparam int LEVEL_W = 12;
  localparam int MAG_W   = 18;
  localparam int TABLE_W = 60;
  localparam int N1_W    = 3;

  // threshold that forces a flip
  localparam logic [LEVEL_W-1:0] ALWAYS_FLIP = 12'hFFF;

  // function codes carried in tuser
  typedef enum logic [1:0] {
    FUNC_METROPOLIS = 2'd0,
    FUNC_WRITE      = 2'd1,
    FUNC_READ       = 2'd2,
    FUNC_UNUSED     = 2'd3
  } func_t;

  // configuration register indexes
  localparam logic CFG_TABLE_UP   = 1'b0;
  localparam logic CFG_TABLE_DOWN = 1'b1;

  // write request to the spin lattice memory
  typedef struct packed {
    logic we;
    logic data;
  } spin_wr_t;

endpackage

### src/isu_lattice.sv
// spin lattice memory with a fill-to-plus-one sweep after reset
module isu_lattice
  import isu_pkg::*;
#(
  parameter int DEPTH  = DEFAULT_WIDTH * DEFAULT_HEIGHT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic              rd_data,
  input  logic [ADDR_W-1:0] wr_addr,
  input  spin_wr_t          wr,
  output logic              busy
);

  logic              mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;
  logic              clearing;

  // sweep every site to +1 after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // single write port, sweep has priority
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 1'b1;
    end else if (wr.we) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign busy = clearing;

endmodule

### src/ising_metropolis_update_unit.sv
// top level: metropolis sequencer, flip tables, magnetization and result register
// flow: an accepted in-range item takes five reads through the single lattice read port, a read
//   drain, a decide step with write-back and a result handoff; out-of-range items go straight to
//   the handoff; no new item is taken before the handoff, which waits while a held beat is not taken
// reset: synchronous; flip tables go to all ones and the sum to WIDTH*HEIGHT, then a sweep
//   sets every spin to +1 with no input taken
module ising_metropolis_update_unit
  import isu_pkg::*;
#(
  parameter int LATTICE_WIDTH  = DEFAULT_WIDTH,
  parameter int LATTICE_HEIGHT = DEFAULT_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  // config write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [TABLE_W-1:0] cfg_data,
  // input stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [31:0]        s_axis_tdata,  // row[7:0], col[15:8], random_level[27:16], spin_value[28]
  input  logic [1:0]         s_axis_tuser,  // func[1:0]
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata   // status[0], flipped[1], site_spin[2], magnetization[20:3]
);

  localparam int SITES  = LATTICE_WIDTH * LATTICE_HEIGHT;
  localparam int ADDR_W = $clog2(SITES);
  localparam int ROW_W  = $clog2(LATTICE_HEIGHT);
  localparam int COL_W  = $clog2(LATTICE_WIDTH);
  localparam logic signed [MAG_W-1:0] MAG_MAX = MAG_W'(SITES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LAST,
    ST_DECIDE,
    ST_DONE
  } state_t;

  state_t state;

  // config tables
  logic [TABLE_W-1:0] table_up;
  logic [TABLE_W-1:0] table_down;

  // item registers
  func_t               func;
  logic [ROW_W-1:0]    row_c, row_m, row_p;
  logic [COL_W-1:0]    col_c, col_m, col_p;
  logic [LEVEL_W-1:0]  level;
  logic                wbit;

  // read sequencing
  logic [2:0]          step;
  logic [2:0]          rd_step;
  logic                rd_valid;
  logic                center;
  logic [N1_W-1:0]     n1;

  // running sum and result
  logic signed [MAG_W-1:0] mag;
  logic                    res_status;
  logic                    res_flipped;
  logic                    res_spin;

  // lattice port signals
  logic [ADDR_W-1:0]   rd_addr;
  logic [ADDR_W-1:0]   site_addr;
  logic                rd_data;
  logic                lat_busy;
  spin_wr_t            wr;

  // input decode
  logic [COORD_W-1:0]  in_row;
  logic [COORD_W-1:0]  in_col;
  logic                in_range;
  logic                accept;

  // decide stage
  logic [LEVEL_W-1:0]  tbl_sel;
  logic [TABLE_W-1:0]  tbl;
  logic                flip;
  logic                new_spin;
  logic                changed;

  assign in_row   = s_axis_tdata[7:0];
  assign in_col   = s_axis_tdata[15:8];
  assign in_range = ({1'b0, in_row} < (COORD_W+1)'(LATTICE_HEIGHT)) &&
                    ({1'b0, in_col} < (COORD_W+1)'(LATTICE_WIDTH));
  assign s_axis_tready = (state == ST_IDLE) && !lat_busy;
  assign accept = s_axis_tvalid && s_axis_tready;

  // neighbor address select for the current read step
  always_comb begin
    logic [ROW_W-1:0] r;
    logic [COL_W-1:0] c;
    r = row_c;
    c = col_c;
    case (step)
      3'd1:    c = col_m;
      3'd2:    c = col_p;
      3'd3:    r = row_m;
      3'd4:    r = row_p;
      default: begin
        r = row_c;
        c = col_c;
      end
    endcase
    rd_addr = ADDR_W'(ADDR_W'(r) * ADDR_W'(LATTICE_WIDTH) + ADDR_W'(c));
  end

  assign site_addr = ADDR_W'(ADDR_W'(row_c) * ADDR_W'(LATTICE_WIDTH) + ADDR_W'(col_c));

  // threshold lookup by up-neighbor count and site spin
  assign tbl = center ? table_up : table_down;
  always_comb begin
    case (n1)
      3'd0:    tbl_sel = tbl[11:0];
      3'd1:    tbl_sel = tbl[23:12];
      3'd2:    tbl_sel = tbl[35:24];
      3'd3:    tbl_sel = tbl[47:36];
      default: tbl_sel = tbl[59:48];
    endcase
  end

  // per-function outcome
  always_comb begin
    flip = 1'b0;
    case (func)
      FUNC_METROPOLIS: begin
        flip     = (tbl_sel == ALWAYS_FLIP) || (level < tbl_sel);
        new_spin = center ^ flip;
      end
      FUNC_WRITE: new_spin = wbit;
      default:    new_spin = center;
    endcase
    changed  = new_spin != center;
    wr.we    = (state == ST_DECIDE) && changed;
    wr.data  = new_spin;
  end

  isu_lattice #(
    .DEPTH  (SITES),
    .ADDR_W (ADDR_W)
  ) u_lattice (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_addr (site_addr),
    .wr      (wr),
    .busy    (lat_busy)
  );

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      table_up   <= '1;
      table_down <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_UP:   table_up   <= cfg_data;
        CFG_TABLE_DOWN: table_down <= cfg_data;
        default:        ;
      endcase
    end
  end

  // sequencer, accumulation, sum and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= '0;
      rd_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      mag           <= MAG_MAX;
    end else begin
      rd_valid <= (state == ST_READ);
      rd_step  <= step;
      if (rd_valid) begin
        if (rd_step == 3'd0) begin
          center <= rd_data;
        end else begin
          n1 <= n1 + N1_W'(rd_data);
        end
      end
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            func  <= func_t'(s_axis_tuser);
            level <= s_axis_tdata[27:16];
            wbit  <= s_axis_tdata[28];
            row_c <= ROW_W'(in_row);
            col_c <= COL_W'(in_col);
            row_m <= (in_row == '0) ? ROW_W'(LATTICE_HEIGHT - 1) : ROW_W'(in_row - 1'b1);
            row_p <= (in_row == COORD_W'(LATTICE_HEIGHT - 1)) ? '0 : ROW_W'(in_row + 1'b1);
            col_m <= (in_col == '0) ? COL_W'(LATTICE_WIDTH - 1) : COL_W'(in_col - 1'b1);
            col_p <= (in_col == COORD_W'(LATTICE_WIDTH - 1)) ? '0 : COL_W'(in_col + 1'b1);
            n1    <= '0;
            step  <= '0;
            if (in_range) begin
              state <= ST_READ;
            end else begin
              res_status  <= 1'b1;
              res_flipped <= 1'b0;
              res_spin    <= 1'b0;
              state       <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          step <= step + 1'b1;
          if (step == 3'd4) begin
            state <= ST_LAST;
          end
        end
        ST_LAST: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (changed) begin
            mag <= new_spin ? mag + MAG_W'(2) : mag - MAG_W'(2);
          end
          res_status  <= 1'b0;
          res_flipped <= flip;
          res_spin    <= new_spin;
          state       <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, mag, res_spin, res_flipped, res_status};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // magnetization never leaves the physical range
  assert property (@(posedge clk) disable iff (rst)
    (mag <= MAG_MAX) && (mag >= -MAG_MAX))
    else $error("magnetization out of range");

  // lattice written by an item only in the decide step
  assert property (@(posedge clk) disable iff (rst)
    wr.we |-> (state == ST_DECIDE))
    else $error("lattice write outside decide step");

  // an error result never reports a flip
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[0]) |-> !m_axis_tdata[1])
    else $error("flip reported on error result");

  // an accepted item always leaves idle
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted item dropped");

  // no item taken while the lattice sweep runs
  assert property (@(posedge clk) disable iff (rst)
    lat_busy |-> !(state == ST_READ || state == ST_DECIDE))
    else $error("item in flight during lattice sweep");
`endif

endmodule

### tb/ising_metropolis_update_unit_test.sv
// self-checking testbench for the ising metropolis update unit: driver, monitor, predictor
`timescale 1ns / 1ps

module ising_metropolis_update_unit_test;
  import isu_pkg::*;

  localparam int LATTICE_W  = DEFAULT_WIDTH;
  localparam int LATTICE_H  = DEFAULT_HEIGHT;
  localparam int SITES      = LATTICE_W * LATTICE_H;
  localparam int HOLD_BEATS = 400;
  localparam int CYCLE_CAP  = 500000;

  // one input item as the block sees it
  typedef struct packed {
    func_t              func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [LEVEL_W-1:0] level;
    logic               spin;
  } site_item_t;

  // one result beat
  typedef struct packed {
    logic                    status;
    logic                    flipped;
    logic                    spin;
    logic signed [MAG_W-1:0] mag;
  } site_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic               cfg_index = CFG_TABLE_UP;
  logic [TABLE_W-1:0] cfg_data = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;  // row[7:0], col[15:8], random_level[27:16], spin_value[28]
  logic [1:0]         s_axis_tuser = '0;  // func[1:0]
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [23:0]        m_axis_tdata;       // status[0], flipped[1], site_spin[2], magnetization[20:3]

  // predictor state
  bit                 spin_map [SITES];
  int                 spin_total;
  logic [TABLE_W-1:0] table_up;
  logic [TABLE_W-1:0] table_down;

  site_item_t   item_queue [$];
  site_result_t expected_results [$];
  site_item_t   cur_item;
  site_result_t got_result;
  site_result_t want_result;
  bit           in_taken = 1'b0;
  bit           steady_in = 1'b0;
  bit           steady_out = 1'b0;
  bit           hold_trigger = 1'b0;
  int           hold_left = 0;
  int           failures = 0;

  ising_metropolis_update_unit #(
    .LATTICE_WIDTH (LATTICE_W),
    .LATTICE_HEIGHT(LATTICE_H)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_CAP) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // lattice update: applies one item to the local lattice and returns its result
  function automatic site_result_t predict_update(input site_item_t it);
    site_result_t       res;
    int                 r;
    int                 c;
    int                 site;
    int                 up_count;
    logic               cur;
    logic [TABLE_W-1:0] tbl;
    logic [LEVEL_W-1:0] thr;
    res = '0;
    r = int'(it.row);
    c = int'(it.col);
    if (r >= LATTICE_H || c >= LATTICE_W) begin
      res.status = 1'b1;
      res.mag = spin_total[MAG_W-1:0];
      return res;
    end
    site = r * LATTICE_W + c;
    cur = spin_map[site];
    case (it.func)
      FUNC_METROPOLIS: begin
        // threshold index is the number of up neighbors on the torus
        up_count = int'(spin_map[r * LATTICE_W + (c + LATTICE_W - 1) % LATTICE_W])
                 + int'(spin_map[r * LATTICE_W + (c + 1) % LATTICE_W])
                 + int'(spin_map[((r + LATTICE_H - 1) % LATTICE_H) * LATTICE_W + c])
                 + int'(spin_map[((r + 1) % LATTICE_H) * LATTICE_W + c]);
        tbl = cur ? table_up : table_down;
        thr = tbl[LEVEL_W*up_count +: LEVEL_W];
        if (thr == ALWAYS_FLIP || it.level < thr) begin
          spin_total += cur ? -2 : 2;
          cur = ~cur;
          spin_map[site] = cur;
          res.flipped = 1'b1;
        end
        res.spin = cur;
      end
      FUNC_WRITE: begin
        if (it.spin != cur) begin
          spin_total += it.spin ? 2 : -2;
          spin_map[site] = it.spin;
        end
        res.spin = it.spin;
      end
      default: begin
        res.spin = cur;
      end
    endcase
    res.mag = spin_total[MAG_W-1:0];
    return res;
  endfunction

  // coordinate: mostly a small window that wraps around the edge, some anywhere, some out of range
  function automatic logic [COORD_W-1:0] random_coord(input int extent);
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) begin
      return COORD_W'((extent - 2 + $urandom_range(3)) % extent);
    end else if (pick < 93) begin
      return COORD_W'($urandom_range(extent - 1));
    end
    return COORD_W'($urandom_range(255, extent));
  endfunction

  function automatic site_item_t random_item();
    site_item_t it;
    int         pick;
    pick = $urandom_range(99);
    it.func = (pick < 48) ? FUNC_METROPOLIS :
              (pick < 75) ? FUNC_WRITE :
              (pick < 94) ? FUNC_READ : FUNC_UNUSED;
    it.row = random_coord(LATTICE_H);
    it.col = random_coord(LATTICE_W);
    pick = $urandom_range(99);
    it.level = (pick < 5) ? '0 : (pick < 10) ? '1 : LEVEL_W'($urandom);
    it.spin = 1'($urandom_range(1));
    return it;
  endfunction

  // five thresholds, each one of zero, always-flip or a random level
  function automatic logic [TABLE_W-1:0] random_table();
    logic [TABLE_W-1:0] tbl;
    int                 pick;
    for (int k = 0; k < 5; k++) begin
      pick = $urandom_range(9);
      tbl[LEVEL_W*k +: LEVEL_W] = (pick < 2) ? '0 : (pick < 4) ? ALWAYS_FLIP : LEVEL_W'($urandom);
    end
    return tbl;
  endfunction

  task automatic push_item(input func_t func, input int row, input int col,
                           input int level, input bit spin);
    site_item_t it;
    it.func = func;
    it.row = COORD_W'(row);
    it.col = COORD_W'(col);
    it.level = LEVEL_W'(level);
    it.spin = spin;
    item_queue.push_back(it);
  endtask

  // wait until every queued item went in and every result came back
  task automatic drain_results();
    @(negedge clk);
    while (item_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (12) @(negedge clk);
  endtask

  // both flip tables, written back to back while idle
  task automatic write_tables(input logic [TABLE_W-1:0] up, input logic [TABLE_W-1:0] down);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_TABLE_UP;
    cfg_data <= up;
    table_up = up;
    @(negedge clk);
    cfg_index <= CFG_TABLE_DOWN;
    cfg_data <= down;
    table_down = down;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!s_axis_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (item_queue.size() != 0 && (steady_in || $urandom_range(99) >= 21)) begin
        cur_item = item_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b000, cur_item.spin, cur_item.level, cur_item.col, cur_item.row};
        s_axis_tuser <= cur_item.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure, with one long hold-off in random phase 2
  always @(negedge clk) begin
    if (hold_trigger) begin
      hold_trigger = 1'b0;
      hold_left = HOLD_BEATS;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_out || ($urandom_range(99) >= 21);
    end
  end

  // monitor: predict on input beats, check result beats
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      expected_results.push_back(predict_update(cur_item));
      in_taken = 1'b1;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_result.status = m_axis_tdata[0];
      got_result.flipped = m_axis_tdata[1];
      got_result.spin = m_axis_tdata[2];
      got_result.mag = m_axis_tdata[20:3];
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_axis_tdata);
        failures++;
      end else begin
        want_result = expected_results.pop_front();
        if (got_result.status !== want_result.status) begin
          $error("status: expected %0d, got %0d", want_result.status, got_result.status);
          failures++;
        end
        if (got_result.flipped !== want_result.flipped) begin
          $error("flipped: expected %0d, got %0d", want_result.flipped, got_result.flipped);
          failures++;
        end
        if (got_result.spin !== want_result.spin) begin
          $error("site_spin: expected %0d, got %0d", want_result.spin, got_result.spin);
          failures++;
        end
        if (got_result.mag !== want_result.mag) begin
          $error("magnetization: expected %0d, got %0d", want_result.mag, got_result.mag);
          failures++;
        end
      end
    end
  end

  // stimulus
  initial begin
    // cold lattice and default tables
    for (int k = 0; k < SITES; k++) begin
      spin_map[k] = 1'b1;
    end
    spin_total = SITES;
    table_up = '1;
    table_down = '1;

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed part, default tables flip on every attempt
    push_item(FUNC_READ, 0, 0, 0, 1'b0);
    push_item(FUNC_READ, LATTICE_H - 1, LATTICE_W - 1, 4095, 1'b1);
    push_item(FUNC_UNUSED, 5, 5, 0, 1'b0);
    push_item(FUNC_READ, LATTICE_H, 0, 0, 1'b0);
    push_item(FUNC_READ, 0, LATTICE_W, 0, 1'b1);
    push_item(FUNC_METROPOLIS, 255, 255, 0, 1'b0);
    push_item(FUNC_WRITE, 200, 3, 4095, 1'b0);
    push_item(FUNC_WRITE, 0, 0, 0, 1'b0);
    push_item(FUNC_WRITE, 0, 0, 0, 1'b0);
    push_item(FUNC_READ, 0, 0, 0, 1'b0);
    push_item(FUNC_METROPOLIS, 0, 0, 4095, 1'b0);
    push_item(FUNC_METROPOLIS, 0, 0, 0, 1'b1);
    push_item(FUNC_WRITE, LATTICE_H - 1, 0, 0, 1'b0);
    push_item(FUNC_WRITE, 1, 0, 0, 1'b0);
    push_item(FUNC_WRITE, 0, LATTICE_W - 1, 0, 1'b0);
    push_item(FUNC_WRITE, 0, 1, 0, 1'b0);
    push_item(FUNC_METROPOLIS, 0, 0, 2048, 1'b0);
    push_item(FUNC_WRITE, 0, 0, 4095, 1'b1);
    push_item(FUNC_METROPOLIS, LATTICE_H - 1, LATTICE_W - 1, 4095, 1'b0);
    push_item(FUNC_METROPOLIS, 1, 1, 2048, 1'b1);
    push_item(FUNC_READ, LATTICE_H - 1, 0, 0, 1'b0);
    push_item(FUNC_UNUSED, LATTICE_H - 1, LATTICE_W - 1, 4095, 1'b1);
    push_item(FUNC_METROPOLIS, 128, 0, 100, 1'b1);
    drain_results();

    // random phases, each under its own table setting
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_tables('0, '0);
        1: write_tables(random_table(), random_table());
        2: write_tables(random_table(), random_table());
        3: write_tables(random_table(), '0);
        4: write_tables('1, '1);
        default: write_tables(random_table(), random_table());
      endcase
      steady_in = (phase == 1) || (phase == 2);
      steady_out = (phase == 1);
      hold_trigger = (phase == 2);
      for (int n = 0; n < ((phase == 4) ? 100 : (phase == 5) ? 300 : 190); n++) begin
        item_queue.push_back(random_item());
      end
      drain_results();
    end

    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### ising_metropolis_update_unit.f
src/isu_pkg.sv
src/isu_lattice.sv
src/ising_metropolis_update_unit.sv
tb/ising_metropolis_update_unit_test.sv
